// File: rtl/tfsi_pkg.sv
// Shared constants and width helpers for the trapezoidal fin set inertia pipeline.
// No dependencies; imported by tfsi_num and the top level.
`timescale 1ns / 1ps
`default_nettype none

package tfsi_pkg;

  localparam int LEN_W        = 32;
  localparam int OUT_W        = 56;
  localparam int OUT_FRAC     = 40;
  localparam int LEN_FRAC_DEF = 24;
  localparam int NUM_LAT      = 13;   // register stages in the numerator datapath
  localparam int NUM_W        = 140;  // clamped numerator width
  localparam int DEN_W        = 73;   // 72 * S^2 width

  function automatic int shl_f(input int f);
    int sh;
    sh = OUT_FRAC - 2 * f;
    return (sh > 0) ? sh : 0;
  endfunction

  function automatic int shr_f(input int f);
    int sh;
    sh = OUT_FRAC - 2 * f;
    return (sh < 0) ? -sh : 0;
  endfunction

  function automatic int nw_f(input int f);
    return NUM_W + 2 + shl_f(f);
  endfunction

  function automatic int dw_f(input int f);
    return DEN_W + 1 + shr_f(f);
  endfunction

endpackage

`default_nettype wire

// File: rtl/tfsi_mul.sv
// Two-stage unsigned multiplier built from 32x32 limb products.
// Stage one registers the limb products, stage two registers their sum. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tfsi_mul #(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic          clk,
  input  logic          en,
  input  logic [AW-1:0] a,
  input  logic [BW-1:0] b,
  output logic [AW+BW-1:0] p
);

  localparam int LA = (AW + 31) / 32;
  localparam int LB = (BW + 31) / 32;
  localparam int XA = LA * 32;
  localparam int XB = LB * 32;
  localparam int SW = XA + XB;

  logic [XA-1:0]    ax;
  logic [XB-1:0]    bx;
  logic [63:0]      pp_r [LA][LB];
  logic [SW-1:0]    acc;
  logic [AW+BW-1:0] p_r;

  assign ax = XA'(a);
  assign bx = XB'(b);

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < LA; i++) begin
        for (int j = 0; j < LB; j++) begin
          pp_r[i][j] <= 64'(ax[32*i +: 32]) * 64'(bx[32*j +: 32]);
        end
      end
    end
  end

  always_comb begin
    acc = '0;
    for (int i = 0; i < LA; i++) begin
      for (int j = 0; j < LB; j++) begin
        acc = acc + (SW'(pp_r[i][j]) << (32 * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= acc[AW+BW-1:0];
    end
  end

  assign p = p_r;

endmodule

`default_nettype wire

// File: rtl/tfsi_num.sv
// Numerator and denominator datapath: second moments, lever arm and the two
// rational inertia terms, formed over NUM_LAT stages. Uses tfsi_pkg and tfsi_mul.
`timescale 1ns / 1ps
`default_nettype none

module tfsi_num #(
  parameter int LEN_FRAC_BITS = tfsi_pkg::LEN_FRAC_DEF
) (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] root_chord,
  input  logic [31:0] tip_chord,
  input  logic [31:0] fin_span,
  input  logic signed [31:0] sweep_offset,
  input  logic [31:0] fin_thickness,
  input  logic [31:0] body_radius,
  output logic [tfsi_pkg::nw_f(LEN_FRAC_BITS)-1:0] num_x,
  output logic [tfsi_pkg::dw_f(LEN_FRAC_BITS)-1:0] den_x,
  output logic [tfsi_pkg::nw_f(LEN_FRAC_BITS)-1:0] num_z,
  output logic [tfsi_pkg::dw_f(LEN_FRAC_BITS)-1:0] den_z,
  output logic        bad
);

  import tfsi_pkg::*;

  localparam int SHL = shl_f(LEN_FRAC_BITS);
  localparam int SHR = shr_f(LEN_FRAC_BITS);
  localparam int NW  = nw_f(LEN_FRAC_BITS);
  localparam int DW  = dw_f(LEN_FRAC_BITS);

  // stage 1
  logic [31:0] cr_r, ct_r, sp_r, th_r, rb_r;
  logic [33:0] x1_r;
  logic [31:0] wm_nxt;
  logic [32:0] csum_r [8];
  logic [31:0] wmag_r [4];
  logic        wneg_r [6];
  logic [33:0] x3_r   [4];
  logic        bad_r  [NUM_LAT];

  // stage 3
  logic [63:0] crcr, ctct, crct, ss, tt, ww;
  logic [65:0] s2, dd1, wx1;
  logic [64:0] srb;

  // stage 4
  logic [66:0] xs_r, y_r;
  logic [67:0] d_r;
  logic [66:0] bm_r;
  logic [64:0] z_r;
  logic [63:0] ss4_r, tt4_r, ww4_r;
  logic [65:0] s2_r [8];
  logic [67:0] bpos, bs, bneg;

  // stage 6
  logic [130:0] pn;
  logic [129:0] t2;
  logic [135:0] dsq;
  logic [133:0] bsq;
  logic [97:0]  a1, a3;
  logic [98:0]  a2;

  // stage 7..13
  logic [100:0] asum;
  logic [100:0] a_r, aneg_v;
  logic [139:0] base_r [6];
  logic [134:0] b2_r   [4];
  logic [99:0]  am_r;
  logic         aneg_r [3];
  logic [132:0] sa;
  logic [134:0] sa3;
  logic [137:0] qpos;
  logic [137:0] qn_r;
  logic [141:0] numx_r;
  logic [72:0]  denx_r, denz_r;
  logic [139:0] nxc;
  logic [NW-1:0] nx_r, nz_r;
  logic [DW-1:0] dx_r, dz_r;

  assign wm_nxt = sweep_offset[31] ? (~sweep_offset + 32'd1) : sweep_offset;

  always_ff @(posedge clk) begin
    if (en) begin
      cr_r      <= root_chord;
      ct_r      <= tip_chord;
      sp_r      <= fin_span;
      th_r      <= fin_thickness;
      rb_r      <= body_radius;
      x1_r      <= 34'(root_chord) + {1'b0, tip_chord, 1'b0};
      csum_r[0] <= 33'(root_chord) + 33'(tip_chord);
      wmag_r[0] <= wm_nxt;
      wneg_r[0] <= sweep_offset[31];
      x3_r[0]   <= 34'(root_chord) + 34'(tip_chord) + {1'b0, tip_chord, 1'b0};
      bad_r[0]  <= (root_chord == 32'd0) && (tip_chord == 32'd0);
      for (int i = 1; i < 8; i++) csum_r[i] <= csum_r[i-1];
      for (int i = 1; i < 4; i++) wmag_r[i] <= wmag_r[i-1];
      for (int i = 1; i < 6; i++) wneg_r[i] <= wneg_r[i-1];
      for (int i = 1; i < 4; i++) x3_r[i]   <= x3_r[i-1];
      for (int i = 1; i < NUM_LAT; i++) bad_r[i] <= bad_r[i-1];
    end
  end

  tfsi_mul #(.AW(32), .BW(32)) u_crcr (.clk, .en, .a(cr_r), .b(cr_r), .p(crcr));
  tfsi_mul #(.AW(32), .BW(32)) u_ctct (.clk, .en, .a(ct_r), .b(ct_r), .p(ctct));
  tfsi_mul #(.AW(32), .BW(32)) u_crct (.clk, .en, .a(cr_r), .b(ct_r), .p(crct));
  tfsi_mul #(.AW(32), .BW(32)) u_ss   (.clk, .en, .a(sp_r), .b(sp_r), .p(ss));
  tfsi_mul #(.AW(32), .BW(32)) u_tt   (.clk, .en, .a(th_r), .b(th_r), .p(tt));
  tfsi_mul #(.AW(32), .BW(32)) u_ww   (.clk, .en, .a(wmag_r[0]), .b(wmag_r[0]), .p(ww));
  tfsi_mul #(.AW(33), .BW(33)) u_s2   (.clk, .en, .a(csum_r[0]), .b(csum_r[0]), .p(s2));
  tfsi_mul #(.AW(32), .BW(34)) u_dd1  (.clk, .en, .a(sp_r), .b(x1_r), .p(dd1));
  tfsi_mul #(.AW(33), .BW(32)) u_srb  (.clk, .en, .a(csum_r[0]), .b(rb_r), .p(srb));
  tfsi_mul #(.AW(32), .BW(34)) u_wx1  (.clk, .en, .a(wmag_r[0]), .b(x1_r), .p(wx1));

  assign bpos = 68'(crcr) + 68'(crct) + 68'(ctct);
  assign bs   = wneg_r[2] ? (bpos - 68'(wx1)) : (bpos + 68'(wx1));
  assign bneg = ~bs + 68'd1;

  always_ff @(posedge clk) begin
    if (en) begin
      xs_r      <= 67'(crcr) + 67'(ctct) + {1'b0, crct, 2'b0};
      d_r       <= 68'(dd1) + 68'(srb) + {2'b0, srb, 1'b0};
      bm_r      <= bs[67] ? bneg[66:0] : bs[66:0];
      y_r       <= 67'(crcr) + {2'b0, crct, 1'b0} + 67'(ctct) + {2'b0, ctct, 1'b0};
      z_r       <= 65'(crcr) + 65'(ctct);
      ss4_r     <= ss;
      tt4_r     <= tt;
      ww4_r     <= ww;
      s2_r[0]   <= s2;
      for (int i = 1; i < 8; i++) s2_r[i] <= s2_r[i-1];
    end
  end

  tfsi_mul #(.AW(64), .BW(67)) u_pn  (.clk, .en, .a(ss4_r), .b(xs_r), .p(pn));
  tfsi_mul #(.AW(64), .BW(66)) u_t2  (.clk, .en, .a(tt4_r), .b(s2_r[0]), .p(t2));
  tfsi_mul #(.AW(68), .BW(68)) u_dsq (.clk, .en, .a(d_r), .b(d_r), .p(dsq));
  tfsi_mul #(.AW(67), .BW(67)) u_bsq (.clk, .en, .a(bm_r), .b(bm_r), .p(bsq));
  tfsi_mul #(.AW(64), .BW(34)) u_a1  (.clk, .en, .a(ww4_r), .b(x3_r[3]), .p(a1));
  tfsi_mul #(.AW(32), .BW(67)) u_a2  (.clk, .en, .a(wmag_r[3]), .b(y_r), .p(a2));
  tfsi_mul #(.AW(33), .BW(65)) u_a3  (.clk, .en, .a(csum_r[3]), .b(z_r), .p(a3));

  assign asum   = 101'(a1) + 101'(a3);
  assign aneg_v = ~a_r + 101'd1;

  always_ff @(posedge clk) begin
    if (en) begin
      a_r       <= wneg_r[5] ? (asum - 101'(a2)) : (asum + 101'(a2));
      base_r[0] <= {8'b0, pn, 1'b0} + 140'(t2) + {9'b0, t2, 1'b0} + {2'b0, dsq, 2'b0};
      b2_r[0]   <= {bsq, 1'b0};
      am_r      <= a_r[100] ? aneg_v[99:0] : a_r[99:0];
      aneg_r[0] <= a_r[100];
      for (int i = 1; i < 6; i++) base_r[i] <= base_r[i-1];
      for (int i = 1; i < 4; i++) b2_r[i]   <= b2_r[i-1];
      for (int i = 1; i < 3; i++) aneg_r[i] <= aneg_r[i-1];
    end
  end

  tfsi_mul #(.AW(33), .BW(100)) u_sa (.clk, .en, .a(csum_r[7]), .b(am_r), .p(sa));

  assign sa3  = 135'(sa) + {1'b0, sa, 1'b0};
  assign qpos = 138'(sa3);
  assign nxc  = numx_r[141] ? '0 : numx_r[139:0];

  always_ff @(posedge clk) begin
    if (en) begin
      qn_r   <= aneg_r[2] ? (-qpos - 138'(b2_r[3])) : (qpos - 138'(b2_r[3]));
      numx_r <= {2'b0, base_r[4]} + {{2{qn_r[137]}}, qn_r, 2'b0};
      denx_r <= {1'b0, s2_r[7], 6'b0} + {4'b0, s2_r[7], 3'b0};
      denz_r <= {2'b0, s2_r[7], 5'b0} + {5'b0, s2_r[7], 2'b0};
      nx_r   <= (NW'(nxc) << (SHL + 1)) + (NW'(denx_r) << SHR);
      dx_r   <= DW'(denx_r) << (SHR + 1);
      nz_r   <= (NW'(base_r[5]) << (SHL + 1)) + (NW'(denz_r) << SHR);
      dz_r   <= DW'(denz_r) << (SHR + 1);
    end
  end

  assign num_x = nx_r;
  assign den_x = dx_r;
  assign num_z = nz_r;
  assign den_z = dz_r;
  assign bad   = bad_r[NUM_LAT-1];

endmodule

`default_nettype wire

// File: rtl/tfsi_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
// Returns floor(num / den) when it fits in QW bits; sat flags a quotient that does not. No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tfsi_div #(
  parameter int NW = 142,
  parameter int DW = 74,
  parameter int QW = 56
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          sat
);

  localparam int CW = (NW > DW + QW) ? NW : DW + QW;

  logic [CW-1:0] rem_r [QW-1];
  logic [DW-1:0] d_r   [QW-1];
  logic [QW-1:0] q_r   [QW];
  logic          sat_r [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stg
    localparam int B = QW - 1 - k;
    logic [CW-1:0] rin, dsh;
    logic [QW-1:0] qin;
    logic [DW-1:0] din;
    logic          sin, ge;

    if (k == 0) begin : g_first
      assign rin = CW'(num);
      assign din = den;
      assign qin = '0;
      assign sin = CW'(num) >= (CW'(den) << QW);
    end else begin : g_next
      assign rin = rem_r[k-1];
      assign din = d_r[k-1];
      assign qin = q_r[k-1];
      assign sin = sat_r[k-1];
    end

    assign dsh = CW'(din) << B;
    assign ge  = rin >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k]   <= qin | (QW'(ge) << B);
        sat_r[k] <= sin;
      end
    end

    if (k < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= ge ? (rin - dsh) : rin;
          d_r[k]   <= din;
        end
      end
    end
  end

  assign quo = q_r[QW-1];
  assign sat = sat_r[QW-1];

endmodule

`default_nettype wire

// File: rtl/trapezoidal_fin_set_inertia.sv
// Top level: trapezoidal fin set moments of inertia per unit mass.
// Uses tfsi_pkg, tfsi_num and tfsi_div; holds the valid chain and output skid.
//
// Usage:
//   Input channel in_*: one fin geometry per transfer (lengths Q8.24 by default).
//   Output channel out_*: Ixx (= Iyy) and Izz in unsigned Q16.40, plus flags.
//   A transfer happens on a rising edge with valid high and stall low.
//   Pipeline: 13 datapath stages, 56 divider stages, then the output register.
//   Throughput: one item per cycle while in_stall is low; the pipeline is fully overlapped.
//   The rate is set by the one-bit-per-stage restoring dividers, which
//   accept a new operand pair each cycle while the pipeline is not frozen.
//   Receiver stall: a one-entry skid buffer catches the item in flight; the
//   whole pipeline then freezes and in_stall rises until the skid drains.
//   in_stall is a registered signal.
//   Reset (rst_n low, synchronous) empties the pipeline and both output
//   registers; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module trapezoidal_fin_set_inertia #(
  parameter int LEN_FRAC_BITS = tfsi_pkg::LEN_FRAC_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_root_chord,
  input  logic [31:0] in_tip_chord,
  input  logic [31:0] in_fin_span,
  input  logic signed [31:0] in_sweep_offset,
  input  logic [31:0] in_fin_thickness,
  input  logic [31:0] in_body_radius,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [tfsi_pkg::OUT_W-1:0] out_transverse_inertia,
  output logic [tfsi_pkg::OUT_W-1:0] out_axial_inertia,
  output logic        out_invalid_geometry,
  output logic        out_saturated
);

  import tfsi_pkg::*;

  localparam int NW       = nw_f(LEN_FRAC_BITS);
  localparam int DW       = dw_f(LEN_FRAC_BITS);
  localparam int PIPE_LAT = NUM_LAT + OUT_W;

  typedef struct packed {
    logic [OUT_W-1:0] ixx;
    logic [OUT_W-1:0] izz;
    logic             inv;
    logic             sat;
  } res_t;

  logic          en;
  logic [NW-1:0] num_x, num_z;
  logic [DW-1:0] den_x, den_z;
  logic          bad;
  logic [OUT_W-1:0] qx, qz;
  logic          satx, satz;
  logic          vld_r  [PIPE_LAT];
  logic          bad_r  [OUT_W];
  logic          out_v_r, skid_v_r;
  res_t          out_r, skid_r, pipe_res;
  logic          pv;

  assign en = !skid_v_r;

  tfsi_num #(.LEN_FRAC_BITS(LEN_FRAC_BITS)) u_num (
    .clk, .en,
    .root_chord   (in_root_chord),
    .tip_chord    (in_tip_chord),
    .fin_span     (in_fin_span),
    .sweep_offset (in_sweep_offset),
    .fin_thickness(in_fin_thickness),
    .body_radius  (in_body_radius),
    .num_x, .den_x, .num_z, .den_z, .bad
  );

  tfsi_div #(.NW(NW), .DW(DW), .QW(OUT_W)) u_div_x (
    .clk, .en, .num(num_x), .den(den_x), .quo(qx), .sat(satx)
  );

  tfsi_div #(.NW(NW), .DW(DW), .QW(OUT_W)) u_div_z (
    .clk, .en, .num(num_z), .den(den_z), .quo(qz), .sat(satz)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      bad_r[0] <= bad;
      for (int i = 1; i < OUT_W; i++) bad_r[i] <= bad_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < PIPE_LAT; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < PIPE_LAT; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  assign pv = vld_r[PIPE_LAT-1];

  always_comb begin
    pipe_res.inv = bad_r[OUT_W-1];
    pipe_res.ixx = bad_r[OUT_W-1] ? '0 : (satx ? '1 : qx);
    pipe_res.izz = bad_r[OUT_W-1] ? '0 : (satz ? '1 : qz);
    pipe_res.sat = !bad_r[OUT_W-1] && (satx || satz);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || !out_stall) begin
      if (skid_v_r) begin
        out_r    <= skid_r;
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_r    <= pipe_res;
        out_v_r  <= pv;
      end
    end else if (pv && !skid_v_r) begin
      skid_r   <= pipe_res;
      skid_v_r <= 1'b1;
    end
  end

  assign in_stall               = skid_v_r;
  assign out_valid              = out_v_r;
  assign out_transverse_inertia = out_r.ixx;
  assign out_axial_inertia      = out_r.izz;
  assign out_invalid_geometry   = out_r.inv;
  assign out_saturated          = out_r.sat;

endmodule

`default_nettype wire

// File: tb/tb.sv
// Testbench for trapezoidal_fin_set_inertia: directed and random fin geometries.
// Results are checked against a wide-integer predictor; depends on tfsi_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
  import tfsi_pkg::*;

  typedef struct packed {
    logic [31:0]        root_chord;
    logic [31:0]        tip_chord;
    logic [31:0]        fin_span;
    logic signed [31:0] sweep_offset;
    logic [31:0]        fin_thickness;
    logic [31:0]        body_radius;
  } fin_geom_t;

  typedef struct packed {
    logic [OUT_W-1:0] transverse;
    logic [OUT_W-1:0] axial;
    logic             invalid;
    logic             saturated;
  } inertia_t;

  localparam int DEN_SHIFT = 2 * LEN_FRAC_DEF - OUT_FRAC;
  localparam int STALL_LIMIT = 3000;

  logic clk, rst_n;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [31:0] in_root_chord, in_tip_chord, in_fin_span, in_fin_thickness, in_body_radius;
  logic signed [31:0] in_sweep_offset;
  logic [OUT_W-1:0] out_transverse_inertia, out_axial_inertia;
  logic out_invalid_geometry, out_saturated;

  inertia_t expected_q[$];
  int errors = 0;
  bit idle_on = 1;
  bit hold_req = 0;
  int hold_cnt = 0;
  int quiet_cycles = 0;

  trapezoidal_fin_set_inertia uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_root_chord(in_root_chord), .in_tip_chord(in_tip_chord),
    .in_fin_span(in_fin_span), .in_sweep_offset(in_sweep_offset),
    .in_fin_thickness(in_fin_thickness), .in_body_radius(in_body_radius),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_transverse_inertia(out_transverse_inertia),
    .out_axial_inertia(out_axial_inertia),
    .out_invalid_geometry(out_invalid_geometry),
    .out_saturated(out_saturated)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  function automatic logic [OUT_W-1:0] round_q1640(logic [255:0] num, logic [255:0] den,
                                                   inout logic sat);
    logic [255:0] q;
    if (num[255]) num = '0;
    den = den << DEN_SHIFT;
    num = (num << 1) + den;
    den = den << 1;
    q = num / den;
    if ((q >> OUT_W) != 0) begin
      sat = 1'b1;
      return {OUT_W{1'b1}};
    end
    return q[OUT_W-1:0];
  endfunction

  function automatic inertia_t fin_inertia(fin_geom_t g);
    logic [255:0] cr, ct, s, w, t, rb, cs;
    logic [255:0] crcr, ctct, crct, x, y, pn, dd, aa, bb, qn, base, s2;
    inertia_t r;
    logic sat;
    r = '0;
    sat = 1'b0;
    cr = 256'(g.root_chord);
    ct = 256'(g.tip_chord);
    s  = 256'(g.fin_span);
    w  = {{224{g.sweep_offset[31]}}, g.sweep_offset};
    t  = 256'(g.fin_thickness);
    rb = 256'(g.body_radius);
    cs = cr + ct;
    if (cs == 0) begin
      r.invalid = 1'b1;
      return r;
    end
    crcr = cr * cr;
    ctct = ct * ct;
    crct = cr * ct;
    x = crct * 4 + crcr + ctct;
    pn = s * s * x;
    x = ct * 2 + cr;
    dd = s * x + cs * rb * 3;
    bb = w * x + crcr + crct + ctct;
    x = ct * 3 + cr;
    aa = w * w * x;
    x = crct * 2 + crcr + ctct * 3;
    aa = aa + x * w;
    aa = aa + (crcr + ctct) * cs;
    qn = cs * aa * 3 - bb * bb * 2;
    s2 = cs * cs;
    base = t * t * s2 * 3 + pn * 2 + dd * dd * 4;
    r.transverse = round_q1640(base + qn * 4, s2 * 72, sat);
    r.axial = round_q1640(base, s2 * 36, sat);
    r.saturated = sat;
    return r;
  endfunction

  function automatic logic [31:0] rand_len();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2, 3: return $urandom;
      default: return $urandom_range(0, 32'h0400_0000);
    endcase
  endfunction

  function automatic fin_geom_t rand_geom();
    fin_geom_t g;
    g.root_chord = rand_len();
    g.tip_chord = rand_len();
    g.fin_span = rand_len();
    g.fin_thickness = rand_len();
    g.body_radius = rand_len();
    case ($urandom_range(0, 5))
      0: g.sweep_offset = $urandom;
      1: g.sweep_offset = 32'sh8000_0000;
      2: g.sweep_offset = 32'sh7FFF_FFFF;
      default: g.sweep_offset = $signed($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000;
    endcase
    if ($urandom_range(0, 19) == 0) begin
      g.root_chord = 0;
      g.tip_chord = 0;
    end
    return g;
  endfunction

  task automatic send_geom(fin_geom_t g);
    in_root_chord <= g.root_chord;
    in_tip_chord <= g.tip_chord;
    in_fin_span <= g.fin_span;
    in_sweep_offset <= g.sweep_offset;
    in_fin_thickness <= g.fin_thickness;
    in_body_radius <= g.body_radius;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    expected_q.push_back(fin_inertia(g));
    while (idle_on && $urandom_range(0, 99) < 34) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_drain();
    while (expected_q.size() != 0) @(posedge clk);
  endtask

  task automatic mk_send(logic [31:0] cr, logic [31:0] ct, logic [31:0] sp,
                         logic signed [31:0] sw, logic [31:0] th, logic [31:0] rb);
    fin_geom_t g;
    g = '{cr, ct, sp, sw, th, rb};
    send_geom(g);
  endtask

  task automatic test_directed();
    mk_send(0, 0, 32'h0100_0000, 0, 32'h0004_0000, 32'h0100_0000);
    mk_send(0, 0, '1, 32'sh8000_0000, '1, '1);
    mk_send(1, 0, 0, 0, 0, 0);
    mk_send(0, 1, 0, 0, 0, 0);
    mk_send('1, '1, '1, 32'sh7FFF_FFFF, '1, '1);
    mk_send('1, '1, '1, 32'sh8000_0000, '1, '1);
    mk_send('1, 0, 0, 0, 0, 0);
    mk_send(0, '1, '1, 32'sh8000_0000, 0, 0);
    mk_send(32'h0100_0000, 32'h0080_0000, 32'h0100_0000, 32'sh0040_0000,
            32'h0004_0000, 32'h0080_0000);
    mk_send(32'h0100_0000, 32'h0100_0000, 32'h0100_0000, 0, 0, 0);
    mk_send(32'h0100_0000, 32'h0100_0000, 0, 32'shFF00_0000, 0, 32'h0100_0000);
    mk_send(32'h1000_0000, 0, 32'h1000_0000, 32'sh1000_0000, 32'h0010_0000, 32'h1000_0000);
    mk_send(1, 1, 1, -1, 1, 1);
    mk_send(32'hFFFF_FFFF, 1, 32'h8000_0000, 32'sh7FFF_FFFF, 32'h8000_0000, 0);
    mk_send(32'h0200_0000, 32'h0100_0000, 32'h2000_0000, 32'shE000_0000, 0, 32'h4000_0000);
    mk_send(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'shAAAA_AAAA,
            32'h5555_5555, 32'hAAAA_AAAA);
    mk_send(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'sh5555_5555,
            32'hAAAA_AAAA, 32'h5555_5555);
    end_burst();
  endtask

  task automatic test_random(int n);
    repeat (n) send_geom(rand_geom());
    end_burst();
  endtask

  task automatic test_full_rate(int n);
    idle_on = 0;
    test_random(n);
    wait_drain();
    idle_on = 1;
  endtask

  task automatic test_backpressure(int n);
    idle_on = 0;
    hold_req = 1;
    test_random(n);
    wait_drain();
    idle_on = 1;
  endtask

  task automatic test_sender_pause(int n);
    test_random(n);
    wait_drain();
    test_random(n);
  endtask

  always @(posedge clk) begin
    if (hold_req) begin
      hold_req = 0;
      hold_cnt = 250;
    end
    if (hold_cnt > 0) begin
      hold_cnt = hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= idle_on && ($urandom_range(0, 99) < 34);
    end
  end

  always @(posedge clk) begin
    inertia_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result transfer", $time);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_transverse_inertia !== e.transverse) begin
          $display("%0t: transverse exp %h got %h", $time, e.transverse,
                   out_transverse_inertia);
          errors++;
        end
        if (out_axial_inertia !== e.axial) begin
          $display("%0t: axial exp %h got %h", $time, e.axial, out_axial_inertia);
          errors++;
        end
        if (out_invalid_geometry !== e.invalid) begin
          $display("%0t: invalid exp %b got %b", $time, e.invalid, out_invalid_geometry);
          errors++;
        end
        if (out_saturated !== e.saturated) begin
          $display("%0t: saturated exp %b got %b", $time, e.saturated, out_saturated);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_root_chord = '0;
    in_tip_chord = '0;
    in_fin_span = '0;
    in_sweep_offset = '0;
    in_fin_thickness = '0;
    in_body_radius = '0;
    out_stall = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(250);
    test_full_rate(100);
    test_backpressure(150);
    test_sender_pause(25);
    wait_drain();
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: trapezoidal_fin_set_inertia.f
rtl/tfsi_pkg.sv
rtl/tfsi_mul.sv
rtl/tfsi_num.sv
rtl/tfsi_div.sv
rtl/trapezoidal_fin_set_inertia.sv
tb/tb.sv
